// ----- rtl/core/dss_pkg.sv -----
// Package for the drum step sequencer with swing.
// Holds the word types, register indexes, field widths and length clamping.
// No dependencies; used by drum_step_sequencer_swing_top.
package dss_pkg;

   localparam int STEP_LIMIT = 64;
   localparam int TIME_BITS = 48;

   localparam int NOW_W   = 48;
   localparam int HUM_W   = 20;
   localparam int PER_W   = 20;
   localparam int LEN_W   = 7;
   localparam int SWING_W = 20;
   localparam int DELAY_W = 21;
   localparam int MASK_W  = 64;
   localparam int IDX_W   = 6;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   // Signed width of delay plus humanize plus swing.
   localparam int SHIFT_W = 23;

   localparam logic [PER_W-1:0] PER_RESET = PER_W'(125000);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
   localparam logic [LEN_W-1:0] NO_STEP   = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLYRHYTHMIC   = 3'd0,
      CSR_STEP_PERIOD    = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_LONGEST_LENGTH = 3'd3,
      CSR_SWING          = 3'd4,
      CSR_DELAY          = 3'd5,
      CSR_STEP_MASK      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [NOW_W-1:0]        now_us;
      logic signed [HUM_W-1:0] humanize_us;
      logic                    force_req;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0] step_index;
      logic             new_step;
      logic             fire;
   } rsp_word_type;

   // A zero length counts as one, a length above STEP_LIMIT as STEP_LIMIT.
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > LEN_W'(STEP_LIMIT)) begin
         r = LEN_W'(STEP_LIMIT);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/drum_step_sequencer_swing_top.sv -----
// Step sequencer for one pattern track, with swing on odd steps.
// Depends on dss_pkg for word types, register indexes and widths.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+----------------------------------
//   req     | in        | req_valid/req_stall | now_us, humanize_us, force_req
//   rsp     | out       | rsp_valid/rsp_stall | step_index, new_step, fire
//   csr     | in        | csr_write_en        | csr_index, csr_wdata
//
// A word passes through the add, multiply and divide states and then the finish state;
// when its first index is odd it is computed again with swing. The restoring
// divider yields one quotient bit per cycle over TIME_BITS + 8 bits.
// Reset is synchronous and active high; it restores the register defaults and history.
// A stalled result waits in the output register while the next request word is taken;
// a finished computation holds in its last state until that register is free.
module drum_step_sequencer_swing_top #(
   parameter int TIME_BITS = dss_pkg::TIME_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  dss_pkg::req_word_type        req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output dss_pkg::rsp_word_type        rsp_data,
   input  logic                         csr_write_en,
   input  logic [dss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dss_pkg::CSR_W-1:0]    csr_wdata
);

   // Shifted time can exceed the time range by the largest shift, so it
   // carries one extra bit. The numerator is time times a length; the
   // divisor is a period times a length.
   localparam int TW  = TIME_BITS + 1;
   localparam int SW  = TW + 1;
   localparam int NW  = TW + dss_pkg::LEN_W;
   localparam int DW  = dss_pkg::PER_W + dss_pkg::LEN_W;
   localparam int CW  = $clog2(NW + 1);
   localparam int LW  = dss_pkg::LEN_W;
   localparam int XW  = dss_pkg::IDX_W;
   localparam int SHW = dss_pkg::SHIFT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic                          poly_ff;
   logic [dss_pkg::PER_W-1:0]     period_ff;
   logic [LW-1:0]                 pat_len_ff;
   logic [LW-1:0]                 longest_ff;
   logic [dss_pkg::SWING_W-1:0]   swing_ff;
   logic signed [dss_pkg::DELAY_W-1:0] delay_ff;
   logic [dss_pkg::MASK_W-1:0]    mask_ff;

   // Sequencer and datapath registers.
   state_type               state_ff, state_in;
   logic                    pass_ff, pass_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   logic signed [SHW-1:0]   shift_ff, shift_in;
   logic                    force_ff, force_in;
   logic [TW-1:0]           t_ff, t_in;
   logic [NW-1:0]           num_ff, num_in;
   logic [DW-1:0]           den_ff, den_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [XW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [LW-1:0]           last_ff, last_in;
   logic [LW-1:0]           prev_ff, prev_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dss_pkg::rsp_word_type   rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic signed [SHW-1:0]   sel_shift;
   logic signed [SW-1:0]    t_sum;
   logic [DW:0]             div_trial;
   logic                    qbit;
   logic [LW-1:0]           mod_trial;
   logic [LW-1:0]           len_clamped;
   logic [LW-1:0]           lon_clamped;
   logic [dss_pkg::PER_W-1:0] period_nz;
   logic                    out_free;
   logic                    step_new;

   // Register writes must arrive only while the sequencer is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff    <= 1'b0;
         period_ff  <= dss_pkg::PER_RESET;
         pat_len_ff <= dss_pkg::LEN_RESET;
         longest_ff <= dss_pkg::LEN_RESET;
         swing_ff   <= '0;
         delay_ff   <= '0;
         mask_ff    <= '0;
      end else if (csr_write_en) begin
         case (dss_pkg::csr_index_type'(csr_index))
            dss_pkg::CSR_POLYRHYTHMIC:   poly_ff    <= csr_wdata[0];
            dss_pkg::CSR_STEP_PERIOD:    period_ff  <= csr_wdata[dss_pkg::PER_W-1:0];
            dss_pkg::CSR_PATTERN_LENGTH: pat_len_ff <= csr_wdata[LW-1:0];
            dss_pkg::CSR_LONGEST_LENGTH: longest_ff <= csr_wdata[LW-1:0];
            dss_pkg::CSR_SWING:          swing_ff   <= csr_wdata[dss_pkg::SWING_W-1:0];
            dss_pkg::CSR_DELAY:          delay_ff   <= $signed(csr_wdata[dss_pkg::DELAY_W-1:0]);
            dss_pkg::CSR_STEP_MASK:      mask_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      // Second pass adds swing to the shift; a negative time clamps to zero.
      sel_shift = pass_ff ? (shift_ff + $signed({3'b000, swing_ff})) : shift_ff;
      t_sum     = $signed({2'b00, now_ff}) + SW'(sel_shift);

      len_clamped = dss_pkg::clamp_len(pat_len_ff);
      lon_clamped = dss_pkg::clamp_len(longest_ff);
      period_nz   = (period_ff == '0) ? dss_pkg::PER_W'(1) : period_ff;

      // Shared restoring divide step. The quotient bit is folded at once
      // into a running residue modulo the pattern length.
      div_trial = {rem_ff, num_ff[NW-1]};
      qbit      = (div_trial >= {1'b0, den_ff});
      mod_trial = {idx_ff, qbit};

      out_free = !rsp_valid_ff || !rsp_stall;
      step_new = force_ff || (({1'b0, idx_ff} != last_ff) && ({1'b0, idx_ff} != prev_ff));
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      now_in       = now_ff;
      shift_in     = shift_ff;
      force_in     = force_ff;
      t_in         = t_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = TIME_BITS'(req_data.now_us);
               shift_in = SHW'(delay_ff) + SHW'($signed(req_data.humanize_us));
               force_in = req_data.force_req;
               pass_in  = 1'b0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            t_in     = t_sum[SW-1] ? '0 : t_sum[TW-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Polyrhythmic mode divides by the period alone.
            if (poly_ff) begin
               num_in = NW'(t_ff);
               den_in = DW'(period_nz);
            end else begin
               num_in = NW'(t_ff) * NW'(len_clamped);
               den_in = DW'(period_nz) * DW'(lon_clamped);
            end
            len_in   = len_clamped;
            rem_in   = '0;
            idx_in   = '0;
            cnt_in   = CW'(NW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? DW'(div_trial - {1'b0, den_ff}) : div_trial[DW-1:0];
            num_in = {num_ff[NW-2:0], 1'b0};
            idx_in = (mod_trial >= len_ff) ? XW'(mod_trial - len_ff) : mod_trial[XW-1:0];
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               if (!pass_ff && idx_in[0]) begin
                  pass_in  = 1'b1;
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.step_index = idx_ff;
               rsp_data_in.new_step   = step_new;
               rsp_data_in.fire       = step_new && mask_ff[idx_ff];
               if (step_new) begin
                  prev_in = last_ff;
                  last_in = {1'b0, idx_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         last_ff      <= dss_pkg::NO_STEP;
         prev_ff      <= dss_pkg::NO_STEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      shift_ff    <= shift_in;
      force_ff    <= force_in;
      t_ff        <= t_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The divider remainder always stays below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // The running step residue always stays below the pattern length.
   a_idx_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, idx_ff} < len_ff))
      else $error("step residue not below pattern length");

   // A fresh result word appears only out of the finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word without finished computation");

   // A step that fires was always accepted as new.
   a_fire_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.fire || rsp_data_ff.new_step))
      else $error("fire without new step");

   // Accepting a new step moves the last step into the older slot.
   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free && step_new) |=> (prev_ff == $past(last_ff)))
      else $error("step history not shifted");
`endif

endmodule

// ----- tb/tb_drum_step_sequencer_swing_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for drum_step_sequencer_swing_top: directed words, then
// randomized track settings with random tick words, checked against a local predictor.
// Depends on dss_pkg for the word types, register indexes and field widths.
module tb_drum_step_sequencer_swing_top;

   // Clock and run control.
   localparam int CLK_HALF        = 10;
   localparam int WATCHDOG_LIMIT  = 2000;
   // The slowest word (odd first index, swing recompute) runs the divider twice,
   // and this margin covers any word still inside the block.
   localparam int SETTLE_CYCLES   = 2 * dss_pkg::TIME_BITS + 40;
   localparam int FIXED_PHASES    = 5;
   localparam int RANDOM_PHASES   = 7;
   localparam int TICKS_PER_PHASE = 80;
   localparam int DIR_COUNT       = 17;

   // An index past the end of the register list; writes to it must be ignored.
   localparam logic [dss_pkg::CSR_IDX_W-1:0] CSR_UNLISTED = 3'd7;

   // One row of the directed stimulus. Rows with typed set carry a result that is
   // obvious from the default settings; all other rows go through the predictor.
   typedef struct packed {
      logic [dss_pkg::NOW_W-1:0] now_us;
      logic [dss_pkg::HUM_W-1:0] humanize_us;
      logic                      force_req;
      logic                      typed;
      logic [dss_pkg::IDX_W-1:0] step_index;
      logic                      new_step;
      logic                      fire;
   } dir_row_type;

   // The directed rows run with the reset settings: stretched mode, 125000 us per
   // step, both lengths 16, no swing, no delay and an empty step mask.
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      // The first tick after reset lands on step 0 and is new.
      {48'd0, 20'h00000, 1'b0, 1'b1, 6'd0, 1'b1, 1'b0},
      // The same step again is not new.
      {48'd0, 20'h00000, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0},
      // Forcing a repeated step accepts it anyway.
      {48'd0, 20'h00000, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0},
      // One step period later gives step 1.
      {48'd125000, 20'h00000, 1'b0, 1'b1, 6'd1, 1'b1, 1'b0},
      // A negative shifted time clamps to zero; step 0 is still in the history.
      {48'd0, 20'h85EE0, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0},
      {48'd250000, 20'h00000, 1'b0, 1'b1, 6'd2, 1'b1, 1'b0},
      // Extremes of time and humanize, and alternating bit patterns.
      {48'hFFFF_FFFF_FFFF, 20'h7FFFF, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'hFFFF_FFFF_FFFF, 20'h80000, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'd0, 20'h7FFFF, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'd0, 20'h80000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      // Just before and at the wrap of the pattern.
      {48'd1999999, 20'h00000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'd2000000, 20'h00000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'd375000, 20'h00000, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'h8000_0000_0000, 20'h00001, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'h0000_0001_0000, 20'hFFFFF, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'h5555_5555_5555, 20'h55555, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
      {48'hAAAA_AAAA_AAAA, 20'hAAAAA, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0}
   };

   // Settings of one track, as held by the register file.
   typedef struct {
      logic                               poly;
      logic [dss_pkg::PER_W-1:0]          period;
      logic [dss_pkg::LEN_W-1:0]          plen;
      logic [dss_pkg::LEN_W-1:0]          lon;
      logic [dss_pkg::SWING_W-1:0]        swing;
      logic signed [dss_pkg::DELAY_W-1:0] delay;
      logic [dss_pkg::MASK_W-1:0]         mask;
   } track_cfg_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   dss_pkg::req_word_type          req_data;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   dss_pkg::rsp_word_type          rsp_data;
   logic                           csr_write_en;
   logic [dss_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dss_pkg::CSR_W-1:0]      csr_wdata;

   // Predictor state: the track settings and the two most recent accepted steps.
   track_cfg_type                  track;
   logic [dss_pkg::LEN_W-1:0]      last_taken;
   logic [dss_pkg::LEN_W-1:0]      prior_taken;

   // Results owed by the block, oldest first.
   dss_pkg::rsp_word_type          steps_due[$];

   int                             fault_count = 0;
   int                             idle_cycles = 0;
   int                             rsp_hold_left = 0;
   // When set, neither side inserts gaps or stalls.
   bit                             steady = 1'b0;

   drum_step_sequencer_swing_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   function automatic void reset_track();
      track.poly   = 1'b0;
      track.period = dss_pkg::PER_RESET;
      track.plen   = dss_pkg::LEN_RESET;
      track.lon    = dss_pkg::LEN_RESET;
      track.swing  = '0;
      track.delay  = '0;
      track.mask   = '0;
      last_taken   = dss_pkg::NO_STEP;
      prior_taken  = dss_pkg::NO_STEP;
   endfunction

   // A length of zero counts as one, and anything above STEP_LIMIT saturates.
   function automatic longint unsigned usable_len(logic [dss_pkg::LEN_W-1:0] v);
      longint unsigned n;
      n = v;
      if (n == 0) begin
         n = 1;
      end else if (n > dss_pkg::STEP_LIMIT) begin
         n = dss_pkg::STEP_LIMIT;
      end
      return n;
   endfunction

   // Step position for a tick at time now with the given total shift.
   function automatic longint unsigned step_at(longint unsigned now, longint shift);
      longint          shifted;
      longint unsigned t;
      longint unsigned per;
      longint unsigned len;
      shifted = longint'(now) + shift;
      if (shifted < 0) begin
         t = 0;
      end else begin
         t = shifted;
      end
      per = (track.period == '0) ? 1 : track.period;
      len = usable_len(track.plen);
      if (track.poly) begin
         return (t / per) % len;
      end
      return ((t * len) / (per * usable_len(track.lon))) % len;
   endfunction

   // Works out the result word for one tick and advances the step history.
   function automatic dss_pkg::rsp_word_type predict_step(dss_pkg::req_word_type w);
      longint                shift;
      longint unsigned       idx;
      logic                  taken;
      dss_pkg::rsp_word_type r;
      shift = longint'(track.delay) + longint'($signed(w.humanize_us));
      idx = step_at(w.now_us, shift);
      // Odd steps are placed again with the swing time added.
      if ((idx % 2) == 1) begin
         idx = step_at(w.now_us, shift + longint'(track.swing));
      end
      taken = (idx != last_taken && idx != prior_taken) || w.force_req;
      r.step_index = dss_pkg::IDX_W'(idx);
      r.new_step   = taken;
      r.fire       = 1'b0;
      if (taken) begin
         prior_taken = last_taken;
         last_taken  = dss_pkg::LEN_W'(idx);
         r.fire      = track.mask[idx % dss_pkg::MASK_W];
      end
      return r;
   endfunction

   // Appends one owed result at the tail of the queue.
   function automatic void owe_step(dss_pkg::rsp_word_type r);
      steps_due.insert(steps_due.size(), r);
   endfunction

   function automatic void apply_register(logic [dss_pkg::CSR_IDX_W-1:0] idx,
                                          logic [dss_pkg::CSR_W-1:0] data);
      case (idx)
         dss_pkg::CSR_POLYRHYTHMIC:   track.poly   = data[0];
         dss_pkg::CSR_STEP_PERIOD:    track.period = data[dss_pkg::PER_W-1:0];
         dss_pkg::CSR_PATTERN_LENGTH: track.plen   = data[dss_pkg::LEN_W-1:0];
         dss_pkg::CSR_LONGEST_LENGTH: track.lon    = data[dss_pkg::LEN_W-1:0];
         dss_pkg::CSR_SWING:          track.swing  = data[dss_pkg::SWING_W-1:0];
         dss_pkg::CSR_DELAY:          track.delay  = data[dss_pkg::DELAY_W-1:0];
         dss_pkg::CSR_STEP_MASK:      track.mask   = data;
         default: ;
      endcase
   endfunction

   // Typical time between steps under the current settings, used to pace the
   // random tick times so that the index walks through the pattern.
   function automatic longint unsigned step_span();
      longint unsigned per;
      longint unsigned s;
      per = (track.period == '0) ? 1 : track.period;
      if (track.poly) begin
         s = per;
      end else begin
         s = per * usable_len(track.lon) / usable_len(track.plen);
      end
      if (s == 0) begin
         s = 1;
      end
      if (s > 64'h3FFF_FFFF) begin
         s = 64'h3FFF_FFFF;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Track settings for each phase
   // ---------------------------------------------------------------------------

   // Hand-picked settings: the extremes of every register, including zero period,
   // zero lengths and lengths above STEP_LIMIT.
   function automatic track_cfg_type fixed_track(int n);
      track_cfg_type c;
      case (n)
         0: begin
            c.poly = 1'b1; c.period = 20'd1; c.plen = 7'd64; c.lon = 7'd64;
            c.swing = 20'd0; c.delay = 21'sd0; c.mask = '1;
         end
         1: begin
            c.poly = 1'b0; c.period = 20'd0; c.plen = 7'd0; c.lon = 7'd0;
            c.swing = 20'hFFFFF; c.delay = 21'h100000; c.mask = 64'hAAAA_AAAA_AAAA_AAAA;
         end
         2: begin
            c.poly = 1'b0; c.period = 20'hFFFFF; c.plen = 7'd127; c.lon = 7'd127;
            c.swing = 20'd1; c.delay = 21'h0FFFFF; c.mask = 64'h5555_5555_5555_5555;
         end
         3: begin
            c.poly = 1'b1; c.period = 20'd125000; c.plen = 7'd3; c.lon = 7'd7;
            c.swing = 20'd62500; c.delay = -21'sd1000; c.mask = 64'h5;
         end
         default: begin
            c.poly = 1'b0; c.period = 20'd1000; c.plen = 7'd7; c.lon = 7'd64;
            c.swing = 20'd333; c.delay = 21'sd250; c.mask = 64'h8000_0000_0000_007F;
         end
      endcase
      return c;
   endfunction

   function automatic track_cfg_type random_track();
      track_cfg_type c;
      c.poly = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       c.period = dss_pkg::PER_W'($urandom);
         1:       c.period = dss_pkg::PER_W'($urandom_range(1, 50));
         default: c.period = dss_pkg::PER_W'($urandom_range(100, 200000));
      endcase
      // Mostly legal lengths, now and then a zero or a saturating value.
      c.plen  = dss_pkg::LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 64));
      c.lon   = dss_pkg::LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 64));
      c.swing = dss_pkg::SWING_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, c.period));
      c.delay = dss_pkg::DELAY_W'(($urandom_range(0, 1) == 0) ? $urandom
                                                              : $urandom_range(0, 4000) - 2000);
      c.mask  = {$urandom, $urandom};
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   task automatic csr_write(input logic [dss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dss_pkg::CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      apply_register(idx, data);
   endtask

   // Writes every register of a track. With noisy set, the bits above each
   // register's width carry random values that the block has to drop.
   task automatic load_track(input track_cfg_type c, input bit noisy);
      logic [dss_pkg::CSR_W-1:0] hi;
      logic [dss_pkg::CSR_W-1:0] data;
      hi = noisy ? {$urandom, $urandom} : '0;
      csr_write(CSR_UNLISTED, {$urandom, $urandom});
      data = hi; data[0] = c.poly;
      csr_write(dss_pkg::CSR_POLYRHYTHMIC, data);
      data = hi; data[dss_pkg::PER_W-1:0] = c.period;
      csr_write(dss_pkg::CSR_STEP_PERIOD, data);
      data = hi; data[dss_pkg::LEN_W-1:0] = c.plen;
      csr_write(dss_pkg::CSR_PATTERN_LENGTH, data);
      data = hi; data[dss_pkg::LEN_W-1:0] = c.lon;
      csr_write(dss_pkg::CSR_LONGEST_LENGTH, data);
      data = hi; data[dss_pkg::SWING_W-1:0] = c.swing;
      csr_write(dss_pkg::CSR_SWING, data);
      data = hi; data[dss_pkg::DELAY_W-1:0] = c.delay;
      csr_write(dss_pkg::CSR_DELAY, data);
      csr_write(dss_pkg::CSR_STEP_MASK, c.mask);
      csr_write_en <= 1'b0;
   endtask

   // Presents one tick word after a random gap and returns at the edge that
   // takes it. Valid is only lowered when a gap is drawn, so a back-to-back word
   // sees a single assignment in its time step.
   task automatic send_word(input dss_pkg::req_word_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until every owed result has come back. At least one
   // edge passes first, so the lowering of valid never shares a step with a
   // following raise.
   task automatic wait_all_steps();
      req_valid <= 1'b0;
      @(posedge clock);
      while (steps_due.size() != 0) @(posedge clock);
   endtask

   function automatic void note_mismatch(string field, longint unsigned want,
                                         longint unsigned got);
      fault_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random stall, and comparison of each accepted word with the
   // oldest owed result.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      dss_pkg::rsp_word_type want;
      if (reset) begin
         rsp_hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (steps_due.size() == 0) begin
               fault_count++;
               $display("%0t: result word with nothing owed, expected none actual %0d/%0d/%0d",
                        $time, rsp_data.step_index, rsp_data.new_step, rsp_data.fire);
            end else begin
               want = steps_due.pop_front();
               if (rsp_data.step_index !== want.step_index) begin
                  note_mismatch("step_index", want.step_index, rsp_data.step_index);
               end
               if (rsp_data.new_step !== want.new_step) begin
                  note_mismatch("new_step", want.new_step, rsp_data.new_step);
               end
               if (rsp_data.fire !== want.fire) begin
                  note_mismatch("fire", want.fire, rsp_data.fire);
               end
            end
            // Each result draws how long the next one is held off.
            rsp_hold_left = steady ? 0 : $urandom_range(0, 6);
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end
         rsp_stall <= (rsp_hold_left != 0);
      end
   end

   // The watchdog ends the run when no word moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
         $display("drum_step_sequencer_swing_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      dss_pkg::req_word_type w;
      dss_pkg::rsp_word_type r;
      track_cfg_type         c;
      longint unsigned       t_run;
      longint unsigned       span;
      longint unsigned       hmag;
      longint                hv;
      int                    phase;
      int                    k;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      reset_track();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings. Typed rows replace the prediction
      // with the obvious answer, but the predictor still runs to track history.
      for (k = 0; k < DIR_COUNT; k++) begin
         w.now_us      = DIR_ROWS[k].now_us;
         w.humanize_us = DIR_ROWS[k].humanize_us;
         w.force_req   = DIR_ROWS[k].force_req;
         send_word(w);
         r = predict_step(w);
         if (DIR_ROWS[k].typed) begin
            r.step_index = DIR_ROWS[k].step_index;
            r.new_step   = DIR_ROWS[k].new_step;
            r.fire       = DIR_ROWS[k].fire;
         end
         owe_step(r);
      end
      wait_all_steps();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Random part: every phase loads a track while the block is idle, then
      // sends ticks whose times mostly advance at the pace of the steps, so the
      // index sweeps the pattern and the history sees new and repeated steps.
      for (phase = 0; phase < FIXED_PHASES + RANDOM_PHASES; phase++) begin
         c = (phase < FIXED_PHASES) ? fixed_track(phase) : random_track();
         load_track(c, phase >= FIXED_PHASES);
         // Some phases run with no gaps and no stalls at all.
         steady = (phase % 4 == 2);
         span   = step_span();
         hmag   = (span / 8 > 250000) ? 250000 : span / 8;
         t_run  = (phase == 0) ? 0 : $urandom_range(0, 1000000);
         for (k = 0; k < TICKS_PER_PHASE; k++) begin
            case ($urandom_range(0, 9))
               0:       t_run = {$urandom, $urandom};
               1:       ;
               default: t_run = t_run + $urandom_range(0, int'(2 * span));
            endcase
            t_run = t_run & ((64'd1 << dss_pkg::NOW_W) - 1);
            w.now_us = t_run[dss_pkg::NOW_W-1:0];
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: w.humanize_us = '0;
               5, 6, 7:       w.humanize_us = dss_pkg::HUM_W'($urandom);
               8:             w.humanize_us = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
               default: begin
                  hv = longint'($urandom_range(0, int'(2 * hmag))) - longint'(hmag);
                  w.humanize_us = dss_pkg::HUM_W'(hv);
               end
            endcase
            w.force_req = ($urandom_range(0, 7) == 0);
            send_word(w);
            owe_step(predict_step(w));
            // Now and then the sender waits for the block to empty completely.
            if ($urandom_range(0, 39) == 0) begin
               wait_all_steps();
            end
         end
         wait_all_steps();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (fault_count == 0 && steps_due.size() == 0) begin
         $display("drum_step_sequencer_swing_top: match");
      end else begin
         $display("drum_step_sequencer_swing_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/dss_pkg.sv
rtl/core/drum_step_sequencer_swing_top.sv
tb/tb_drum_step_sequencer_swing_top.sv
